/* design/bhrc_pkg.sv */
// shared types, widths and register codes for the breath and heart rate counter
package bhrc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 10;

    localparam int ALPHA_W   = 17;
    localparam int THRESH_W  = 25;
    localparam int REFR_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 25;

    localparam logic [ALPHA_W-1:0] ALPHA_UNITY = 17'h10000;

    localparam logic [ALPHA_W-1:0]  BREATH_ALPHA_RST = 17'd655;
    localparam logic [ALPHA_W-1:0]  HEART_ALPHA_RST  = 17'd19661;
    localparam logic [THRESH_W-1:0] THRESH_RST       = 25'd60;
    localparam logic [REFR_W-1:0]   REFR_RST         = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BREATH_ALPHA = 2'd0,
        CFG_HEART_ALPHA  = 2'd1,
        CFG_BEAT_THRESH  = 2'd2,
        CFG_REFR_LENGTH  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]  breath_alpha;
        logic [ALPHA_W-1:0]  heart_alpha;
        logic [THRESH_W-1:0] beat_threshold;
        logic [REFR_W-1:0]   refractory_length;
    } cfg_t;

    typedef struct packed {
        logic seed;
        logic eval;
        logic last;
    } step_ctl_t;

endpackage

/* design/bhrc_cfg_regs.sv */
// configuration register file written through the config channel
module bhrc_cfg_regs
    import bhrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BREATH_ALPHA: cfg_next.breath_alpha      = cfg_data[ALPHA_W-1:0];
                CFG_HEART_ALPHA:  cfg_next.heart_alpha       = cfg_data[ALPHA_W-1:0];
                CFG_BEAT_THRESH:  cfg_next.beat_threshold    = cfg_data[THRESH_W-1:0];
                CFG_REFR_LENGTH:  cfg_next.refractory_length = cfg_data[REFR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.breath_alpha      <= BREATH_ALPHA_RST;
            cfg_reg.heart_alpha       <= HEART_ALPHA_RST;
            cfg_reg.beat_threshold    <= THRESH_RST;
            cfg_reg.refractory_length <= REFR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/bhrc_ema.sv */
// first-order low-pass filter step with its level register
module bhrc_ema
    import bhrc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   seed,
    input  logic [SAMPLE_BITS-1:0] x,
    input  logic [ALPHA_W-1:0]     alpha,
    output logic [SAMPLE_BITS-1:0] y_new,
    output logic [SAMPLE_BITS-1:0] level
);

    localparam int PROD_W = SAMPLE_BITS + 1 + ALPHA_W + 1;

    logic [SAMPLE_BITS-1:0]     level_reg;
    logic [ALPHA_W-1:0]         alpha_clamp;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [ALPHA_W:0]    alpha_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   step;
    logic [SAMPLE_BITS:0]       sum;

    // y + floor(a*(x-y)/65536) equals floor((a*x + (65536-a)*y)/65536)
    assign alpha_clamp = (alpha > ALPHA_UNITY) ? ALPHA_UNITY : alpha;
    assign alpha_s     = signed'({1'b0, alpha_clamp});
    assign diff        = signed'({1'b0, x}) - signed'({1'b0, level_reg});
    assign prod        = PROD_W'(diff) * PROD_W'(alpha_s);
    assign step        = prod >>> 16;
    assign sum         = {1'b0, level_reg} + step[SAMPLE_BITS:0];
    assign y_new       = seed ? x : sum[SAMPLE_BITS-1:0];
    assign level       = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (en) begin
            level_reg <= y_new;
        end
    end

endmodule

/* design/bhrc_detect.sv */
// breath peak and heartbeat detection with saturating window tallies
module bhrc_detect
    import bhrc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  step_ctl_t              ctl,
    input  cfg_t                   cfg,
    input  logic [SAMPLE_BITS-1:0] slow_level,
    input  logic [SAMPLE_BITS-1:0] slow_new,
    input  logic [SAMPLE_BITS-1:0] fast_before,
    input  logic [SAMPLE_BITS-1:0] fast_level,
    input  logic [SAMPLE_BITS-1:0] fast_new,
    output logic [COUNT_BITS-1:0]  breath_count,
    output logic [COUNT_BITS-1:0]  beat_count
);

    localparam int MAG_W = (SAMPLE_BITS + 1 > THRESH_W) ? SAMPLE_BITS + 1 : THRESH_W;

    logic                  rising_reg, rising_next, rising_upd;
    logic [REFR_W-1:0]     holdoff_reg, holdoff_next, holdoff_upd;
    logic [COUNT_BITS-1:0] peak_reg, peak_next, peak_upd;
    logic [COUNT_BITS-1:0] beat_reg, beat_next, beat_upd;

    logic [SAMPLE_BITS:0] twice;
    logic [SAMPLE_BITS:0] sides;
    logic [SAMPLE_BITS:0] mag;
    logic                 over;

    assign twice = {fast_level, 1'b0};
    assign sides = {1'b0, fast_before} + {1'b0, fast_new};
    assign mag   = (twice >= sides) ? twice - sides : sides - twice;
    assign over  = MAG_W'(mag) > MAG_W'(cfg.beat_threshold);

    always_comb begin
        rising_upd  = rising_reg;
        holdoff_upd = holdoff_reg;
        peak_upd    = peak_reg;
        beat_upd    = beat_reg;
        if (!ctl.seed) begin
            if (slow_new > slow_level) begin
                rising_upd = 1'b1;
            end else if (slow_new < slow_level && rising_reg) begin
                if (peak_reg != '1) peak_upd = peak_reg + 1'b1;
                rising_upd = 1'b0;
            end
        end
        if (ctl.eval) begin
            if (holdoff_reg == '0) begin
                if (over) begin
                    if (beat_reg != '1) beat_upd = beat_reg + 1'b1;
                    holdoff_upd = (cfg.refractory_length != '0)
                                ? cfg.refractory_length - 1'b1 : '0;
                end
            end else begin
                holdoff_upd = holdoff_reg - 1'b1;
            end
        end
    end

    assign breath_count = peak_upd;
    assign beat_count   = beat_upd;

    // window end clears the tallies and flags
    assign rising_next  = ctl.last ? 1'b0 : rising_upd;
    assign holdoff_next = ctl.last ? '0   : holdoff_upd;
    assign peak_next    = ctl.last ? '0   : peak_upd;
    assign beat_next    = ctl.last ? '0   : beat_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rising_reg  <= 1'b0;
            holdoff_reg <= '0;
            peak_reg    <= '0;
            beat_reg    <= '0;
        end else if (en) begin
            rising_reg  <= rising_next;
            holdoff_reg <= holdoff_next;
            peak_reg    <= peak_next;
            beat_reg    <= beat_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        en && ctl.last |=> peak_reg == '0 && beat_reg == '0 && holdoff_reg == '0)
        else $error("tallies not cleared after window end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        en && ctl.seed |-> !rising_upd && peak_upd == peak_reg && beat_upd == beat_reg)
        else $error("seed sample changed detection state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        en && !ctl.last |=> holdoff_reg < REFR_W'(15))
        else $error("holdoff out of range");

endmodule

/* design/breath_heart_rate_counter_top.sv */
// top level of the breath and heart rate counter
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata sample, s_tlast last_in_window
//  m_        out        m_tvalid/m_tready   m_tdata filtered values and counts,
//                                           m_tlast window_done
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item per cycle sustained while m_tready allows; an item passes through the
// input register, then the result register
// both filters, the detector and the window counter step once per item
// a stalled result holds the item in the input register; intake stops only
// when both registers are full
// synchronous active-low reset clears all but data registers, loads cfg defaults
module breath_heart_rate_counter_top
    import bhrc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]               s_tdata,
    input  logic                                           s_tlast,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // breath_filtered, heart_filtered, breath_count, beat_count
    output logic [((2*SAMPLE_BITS+2*COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                           m_tlast,
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]                           cfg_index,
    input  logic [CFG_DAT_W-1:0]                           cfg_data
);

    localparam int M_W   = ((2*SAMPLE_BITS+2*COUNT_BITS+7)/8)*8;
    localparam int PAY_W = 2*SAMPLE_BITS + 2*COUNT_BITS;

    cfg_t cfg;

    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;
    logic [1:0]             win_cnt_reg, win_cnt_next;
    logic [SAMPLE_BITS-1:0] fast_before_reg;

    logic                   out_vld_reg;
    logic [PAY_W-1:0]       out_pay_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   fire;
    step_ctl_t              ctl;

    logic [SAMPLE_BITS-1:0] slow_new, slow_level;
    logic [SAMPLE_BITS-1:0] fast_new, fast_level;
    logic [COUNT_BITS-1:0]  breath_count, beat_count;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    assign ctl.seed = (win_cnt_reg == 2'd0);
    assign ctl.eval = (win_cnt_reg == 2'd2);
    assign ctl.last = in_last_reg;

    assign win_cnt_next = in_last_reg ? 2'd0
                        : (win_cnt_reg == 2'd2) ? 2'd2 : win_cnt_reg + 2'd1;

    bhrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bhrc_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_slow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (fire),
        .seed    (ctl.seed),
        .x       (in_sample_reg),
        .alpha   (cfg.breath_alpha),
        .y_new   (slow_new),
        .level   (slow_level)
    );

    bhrc_ema #(.SAMPLE_BITS(SAMPLE_BITS)) u_fast (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (fire),
        .seed    (ctl.seed),
        .x       (in_sample_reg),
        .alpha   (cfg.heart_alpha),
        .y_new   (fast_new),
        .level   (fast_level)
    );

    bhrc_detect #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_detect (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (fire),
        .ctl          (ctl),
        .cfg          (cfg),
        .slow_level   (slow_level),
        .slow_new     (slow_new),
        .fast_before  (fast_before_reg),
        .fast_level   (fast_level),
        .fast_new     (fast_new),
        .breath_count (breath_count),
        .beat_count   (beat_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cnt_reg     <= 2'd0;
            fast_before_reg <= '0;
        end else if (fire) begin
            win_cnt_reg     <= win_cnt_next;
            fast_before_reg <= fast_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_pay_reg  <= {beat_count, breath_count, fast_new, slow_new};
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_W'(out_pay_reg);
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        win_cnt_reg != 2'd3)
        else $error("window sample count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> win_cnt_reg == 2'd0)
        else $error("window count not cleared after last item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_vld_reg)
        else $error("processed item did not reach result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_free |=> in_vld_reg && $stable(in_sample_reg))
        else $error("held input item lost");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the breath and heart rate counter top level
module tb_top;
    import bhrc_pkg::*;

    localparam int SW         = SAMPLE_BITS_DEF;
    localparam int CW         = COUNT_BITS_DEF;
    localparam int S_DATA_W   = ((SW + 7) / 8) * 8;
    localparam int M_DATA_W   = ((2 * SW + 2 * CW + 7) / 8) * 8;
    localparam int PIPE_DEPTH = 2;
    localparam int STALL_MAX  = 2000;

    typedef struct packed {
        logic [SW-1:0] breath_filtered;
        logic [SW-1:0] heart_filtered;
        logic [CW-1:0] breath_count;
        logic [CW-1:0] beat_count;
        logic          window_done;
    } rate_result_t;

    class rate_scoreboard;
        logic [ALPHA_W-1:0]  breath_alpha;
        logic [ALPHA_W-1:0]  heart_alpha;
        logic [THRESH_W-1:0] beat_threshold;
        logic [REFR_W-1:0]   refractory_length;
        logic [SW-1:0]       slow_level;
        logic [SW-1:0]       fast_level;
        logic [SW-1:0]       fast_prev;
        logic                rising;
        logic [1:0]          seen;
        logic [REFR_W-1:0]   holdoff;
        logic [CW-1:0]       peaks;
        logic [CW-1:0]       beats;
        rate_result_t        expected[$];
        int                  errors;

        function new();
            breath_alpha      = BREATH_ALPHA_RST;
            heart_alpha       = HEART_ALPHA_RST;
            beat_threshold    = THRESH_RST;
            refractory_length = REFR_RST;
            slow_level        = '0;
            fast_level        = '0;
            fast_prev         = '0;
            rising            = 1'b0;
            seen              = '0;
            holdoff           = '0;
            peaks             = '0;
            beats             = '0;
            errors            = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_BREATH_ALPHA: breath_alpha = val[ALPHA_W-1:0];
                CFG_HEART_ALPHA:  heart_alpha = val[ALPHA_W-1:0];
                CFG_BEAT_THRESH:  beat_threshold = val[THRESH_W-1:0];
                CFG_REFR_LENGTH:  refractory_length = val[REFR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SW-1:0] blend(logic [SW-1:0] x, logic [SW-1:0] y,
                                      logic [ALPHA_W-1:0] alpha);
            logic [63:0] a;
            logic [63:0] acc;
            a   = (alpha > ALPHA_UNITY) ? 64'(ALPHA_UNITY) : 64'(alpha);
            acc = a * 64'(x) + (64'(ALPHA_UNITY) - a) * 64'(y);
            return acc[SW+15:16];
        endfunction

        function logic [CW-1:0] bump(logic [CW-1:0] n);
            return (n != '1) ? n + 1'b1 : n;
        endfunction

        function void note_sample(logic [SW-1:0] smp, logic last);
            logic [SW-1:0] slow_new;
            logic [SW-1:0] fast_new;
            logic [SW+1:0] twice;
            logic [SW+1:0] sides;
            logic [SW+1:0] mag;
            rate_result_t  res;
            if (seen == 0) begin
                slow_new = smp;
                fast_new = smp;
            end else begin
                slow_new = blend(smp, slow_level, breath_alpha);
                fast_new = blend(smp, fast_level, heart_alpha);
                if (slow_new > slow_level) begin
                    rising = 1'b1;
                end else if (slow_new < slow_level && rising) begin
                    peaks  = bump(peaks);
                    rising = 1'b0;
                end
                if (seen >= 2) begin
                    twice = {1'b0, fast_level, 1'b0};
                    sides = (SW+2)'(fast_prev) + (SW+2)'(fast_new);
                    mag   = (twice >= sides) ? twice - sides : sides - twice;
                    if (holdoff == 0) begin
                        if (mag > (SW+2)'(beat_threshold)) begin
                            beats   = bump(beats);
                            holdoff = (refractory_length != 0) ? refractory_length - 1'b1 : '0;
                        end
                    end else begin
                        holdoff = holdoff - 1'b1;
                    end
                end
            end
            fast_prev  = fast_level;
            slow_level = slow_new;
            fast_level = fast_new;
            if (seen < 2) seen = seen + 1'b1;
            res.breath_filtered = slow_new;
            res.heart_filtered  = fast_new;
            res.breath_count    = peaks;
            res.beat_count      = beats;
            res.window_done     = last;
            expected.push_back(res);
            if (last) begin
                peaks   = '0;
                beats   = '0;
                rising  = 1'b0;
                holdoff = '0;
                seen    = '0;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] tdata, logic tlast);
            rate_result_t exp_res;
            rate_result_t got;
            got.breath_filtered = tdata[SW-1:0];
            got.heart_filtered  = tdata[2*SW-1:SW];
            got.breath_count    = tdata[2*SW+CW-1:2*SW];
            got.beat_count      = tdata[2*SW+2*CW-1:2*SW+CW];
            got.window_done     = tlast;
            if (expected.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            exp_res = expected.pop_front();
            if (got.breath_filtered !== exp_res.breath_filtered) begin
                $error("breath_filtered: expected %0h, actual %0h",
                       exp_res.breath_filtered, got.breath_filtered);
                errors++;
            end
            if (got.heart_filtered !== exp_res.heart_filtered) begin
                $error("heart_filtered: expected %0h, actual %0h",
                       exp_res.heart_filtered, got.heart_filtered);
                errors++;
            end
            if (got.breath_count !== exp_res.breath_count) begin
                $error("breath_count: expected %0d, actual %0d",
                       exp_res.breath_count, got.breath_count);
                errors++;
            end
            if (got.beat_count !== exp_res.beat_count) begin
                $error("beat_count: expected %0d, actual %0d",
                       exp_res.beat_count, got.beat_count);
                errors++;
            end
            if (got.window_done !== exp_res.window_done) begin
                $error("window_done: expected %0b, actual %0b",
                       exp_res.window_done, got.window_done);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_BREATH_ALPHA;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    rate_scoreboard sb;
    bit             gaps_on = 1'b1;
    int             quiet_cycles = 0;

    breath_heart_rate_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= 19) : 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [SW-1:0] smp, input logic last);
        while (gaps_on && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(smp);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(smp, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [ALPHA_W-1:0] ba, input logic [ALPHA_W-1:0] ha,
                                 input logic [THRESH_W-1:0] th, input logic [REFR_W-1:0] rl);
        cfg_index_t           idx;
        logic [CFG_DAT_W-1:0] val;
        for (int k = 0; k < 4; k++) begin
            idx = cfg_index_t'(k);
            case (idx)
                CFG_BREATH_ALPHA: val = CFG_DAT_W'(ba);
                CFG_HEART_ALPHA:  val = CFG_DAT_W'(ha);
                CFG_BEAT_THRESH:  val = CFG_DAT_W'(th);
                default:          val = CFG_DAT_W'(rl);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(idx, val);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mode: 0 noise, 1 small ripple, 2 alternating extremes, 3 triangle; -1 picks per window
    task automatic run_windows(input int n_items, input int min_len, input int max_len,
                               input int mode_sel);
        int            sent;
        int            len;
        int            mode;
        int            per;
        int            pos;
        logic [SW-1:0] base;
        logic [SW-1:0] step;
        logic [SW-1:0] smp;
        sent = 0;
        while (sent < n_items) begin
            len  = $urandom_range(min_len, max_len);
            mode = (mode_sel < 0) ? $urandom_range(3) : mode_sel;
            base = SW'($urandom());
            step = SW'($urandom_range(1, 1 << $urandom_range(0, 18)));
            per  = $urandom_range(4, 32);
            for (int i = 0; i < len; i++) begin
                pos = i % per;
                case (mode)
                    0: smp = SW'($urandom());
                    1: smp = base + SW'($urandom_range(0, 1023));
                    2: smp = (i % 2) ? '1 - SW'($urandom_range(0, 15))
                                     : SW'($urandom_range(0, 15));
                    default: smp = base + step * SW'((pos < per / 2) ? pos : per - pos);
                endcase
                send_sample(smp, i == len - 1);
            end
            sent += len;
        end
        drain();
    endtask

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        if ($urandom_range(7) == 0) return ALPHA_W'($urandom_range(65537, 131071));
        return ALPHA_W'($urandom_range(0, 65536));
    endfunction

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-sample windows at both extremes, then short shaped windows
        send_sample('1, 1'b1);
        send_sample('0, 1'b1);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(SW'(24'h123456), 1'b0);
        send_sample(SW'(24'hEDCBA9), 1'b1);
        send_sample(SW'(24'h555555), 1'b0);
        send_sample(SW'(24'hAAAAAA), 1'b0);
        send_sample(SW'(24'h555555), 1'b0);
        send_sample(SW'(24'hAAAAAA), 1'b1);
        drain();

        run_windows(40, 1, 16, -1);

        apply_setting(ALPHA_UNITY, ALPHA_UNITY, '0, 4'd1);
        run_windows(24, 1, 12, -1);

        apply_setting('0, '0, '1, 4'd15);
        run_windows(16, 1, 8, -1);

        apply_setting('1, '1, 25'd1000, 4'd0);
        run_windows(24, 1, 12, -1);

        // long window so both counts reach saturation
        gaps_on = 1'b0;
        apply_setting(ALPHA_UNITY, ALPHA_UNITY, '0, 4'd1);
        run_windows(2052, 2052, 2052, 2);
        gaps_on = 1'b1;

        repeat (3) begin
            apply_setting(pick_alpha(), pick_alpha(),
                          THRESH_W'($urandom_range(0, 32'h1FFFFFF) >> $urandom_range(0, 24)),
                          REFR_W'($urandom_range(0, 15)));
            run_windows(16, 1, 12, -1);
        end

        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
design/bhrc_pkg.sv
design/bhrc_cfg_regs.sv
design/bhrc_ema.sv
design/bhrc_detect.sv
design/breath_heart_rate_counter_top.sv
tb/tb_top.sv
